/* rtl/svt_pkg.sv */
// Shared types, register indexes and the saturation helper for the spatial vector transform.
package svt_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROT_ROW_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_POS_X     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_POS_Y     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_POS_Z     = 3'd5;

  // Vector kinds carried in the command field.
  localparam logic CMD_MOTION = 1'b0;
  localparam logic CMD_FORCE  = 1'b1;

  // Register widths and reset values (identity rotation, zero position).
  localparam int unsigned RotW = 48;
  localparam int unsigned PosW = 32;
  localparam logic [RotW-1:0] ROT_ROW_0_RST = 48'h0000_0000_4000;
  localparam logic [RotW-1:0] ROT_ROW_1_RST = 48'h0000_4000_0000;
  localparam logic [RotW-1:0] ROT_ROW_2_RST = 48'h4000_0000_0000;

  // Saturation bounds of a Q16.16 result.
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Input transaction.
  typedef struct packed {
    logic               command;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic signed [31:0] out_lin_x;
    logic signed [31:0] out_lin_y;
    logic signed [31:0] out_lin_z;
    logic signed [31:0] out_ang_x;
    logic signed [31:0] out_ang_y;
    logic signed [31:0] out_ang_z;
    logic               saturated;
  } out_item_t;

  // Hand-off between the rotation stages and the cross product stages.
  typedef struct packed {
    logic              command;
    logic              clip;
    logic [2:0][31:0]  first;
    logic [2:0][49:0]  rs;
  } mid_t;

  // Saturated value together with its clip flag.
  typedef struct packed {
    logic               clip;
    logic signed [31:0] value;
  } sat_t;

  // Clip a 50-bit signed value into the 32-bit signed range.
  function automatic sat_t sat32(input logic signed [49:0] x);
    sat_t r;
    r.clip = (x[49:31] != {19{x[49]}});
    if (r.clip) begin
      r.value = x[49] ? SAT_MIN : SAT_MAX;
    end else begin
      r.value = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/svt_rot_mul.sv */
// Rotation stages: row products of R with both vector halves, then sums, rounding and clip.
module svt_rot_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    item_valid,
  input  svt_pkg::in_item_t       item,
  input  logic [2:0][47:0]        rot,
  output logic                    mid_valid,
  output svt_pkg::mid_t           mid
);

  logic signed [31:0] src1 [3];
  logic signed [31:0] src2 [3];
  logic signed [47:0] p1_next [3][3];
  logic signed [47:0] p2_next [3][3];
  logic signed [47:0] p1 [3][3];
  logic signed [47:0] p2 [3][3];
  logic               cmd1;
  logic               v1;
  logic signed [49:0] sum1 [3];
  logic signed [49:0] sum2 [3];
  svt_pkg::sat_t      sr [3];
  svt_pkg::mid_t      mid_next;

  // The rotated-only half comes first; the other half later gets the cross product.
  always_comb begin
    if (item.command == svt_pkg::CMD_FORCE) begin
      src1[0] = item.lin_x; src1[1] = item.lin_y; src1[2] = item.lin_z;
      src2[0] = item.ang_x; src2[1] = item.ang_y; src2[2] = item.ang_z;
    end else begin
      src1[0] = item.ang_x; src1[1] = item.ang_y; src1[2] = item.ang_z;
      src2[0] = item.lin_x; src2[1] = item.lin_y; src2[2] = item.lin_z;
    end
  end

  // Stage 1 multipliers: Q1.14 entries times Q16.16 components, exact.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        p1_next[i][c] = 48'($signed(rot[i][16*c +: 16])) * 48'(src1[c]);
        p2_next[i][c] = 48'($signed(rot[i][16*c +: 16])) * 48'(src2[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= p1_next;
      p2   <= p2_next;
      cmd1 <= item.command;
    end
  end

  // Stage 2: row sums; the first half is floored by 2^14 and clipped.
  always_comb begin
    mid_next.command = cmd1;
    mid_next.clip    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum1[i] = 50'(p1[i][0]) + 50'(p1[i][1]) + 50'(p1[i][2]);
      sum2[i] = 50'(p2[i][0]) + 50'(p2[i][1]) + 50'(p2[i][2]);
      sr[i]   = svt_pkg::sat32(50'($signed(sum1[i][49:14])));
      mid_next.first[i] = sr[i].value;
      mid_next.rs[i]    = sum2[i];
      mid_next.clip     = mid_next.clip | sr[i].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= mid_next;
    end
  end

endmodule

/* rtl/svt_cross.sv */
// Cross product stages: p x first, then the exact sum with the second rotation, floor and clip.
module svt_cross (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    mid_valid,
  input  svt_pkg::mid_t           mid,
  input  logic [2:0][31:0]        pos,
  output logic                    res_valid,
  output svt_pkg::out_item_t      res
);

  logic signed [63:0] a_next [3];
  logic signed [63:0] b_next [3];
  logic signed [63:0] a [3];
  logic signed [63:0] b [3];
  logic signed [49:0] rs3 [3];
  logic signed [31:0] first3 [3];
  logic               cmd3;
  logic               clip3;
  logic               v3;
  logic signed [65:0] t [3];
  svt_pkg::sat_t      sr [3];
  logic signed [31:0] second [3];
  logic signed [31:0] lin [3];
  logic signed [31:0] ang [3];
  logic               clip4;
  svt_pkg::out_item_t res_next;

  // Stage 3 multipliers: the two terms of each cross product component.
  always_comb begin
    int j;
    int k;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      a_next[i] = 64'($signed(pos[j])) * 64'($signed(mid.first[k]));
      b_next[i] = 64'($signed(pos[k])) * 64'($signed(mid.first[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a     <= a_next;
      b     <= b_next;
      cmd3  <= mid.command;
      clip3 <= mid.clip;
      for (int i = 0; i < 3; i++) begin
        rs3[i]    <= $signed(mid.rs[i]);
        first3[i] <= $signed(mid.first[i]);
      end
    end
  end

  // Stage 4: rotation term scaled to Q.32 plus the cross product, floored by 2^16.
  always_comb begin
    clip4 = clip3;
    for (int i = 0; i < 3; i++) begin
      t[i]      = (66'(rs3[i]) <<< 2) + 66'(a[i]) - 66'(b[i]);
      sr[i]     = svt_pkg::sat32($signed(t[i][65:16]));
      second[i] = sr[i].value;
      clip4     = clip4 | sr[i].clip;
      lin[i]    = (cmd3 == svt_pkg::CMD_FORCE) ? first3[i] : second[i];
      ang[i]    = (cmd3 == svt_pkg::CMD_FORCE) ? second[i] : first3[i];
    end
    res_next.out_lin_x = lin[0];
    res_next.out_lin_y = lin[1];
    res_next.out_lin_z = lin[2];
    res_next.out_ang_x = ang[0];
    res_next.out_ang_y = ang[1];
    res_next.out_ang_z = ang[2];
    res_next.saturated = clip4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/spatial_vector_transform.sv */
// Top level of the spatial vector transform: configuration registers and the pipeline.
//
// Applies the rigid transform held in configuration (rotation rows in Q1.14,
// position in Q16.16) to one six-component spatial vector per transaction.
// command selects a motion vector (angular part rotated, linear part rotated
// plus p x angular') or a force vector (linear part rotated, angular part
// rotated plus p x linear'). Results are floored, clipped to 32 bits, and
// saturated reports any clip.
// Channels: src carries input transactions, dst carries results, both with
// valid and stall. The configuration port is write-only (cfg_we, cfg_index,
// cfg_data). The user must see that it is written while no transaction is in
// flight; the block itself does not enforce this. Indexes above the position
// registers are ignored. Between acceptance and dst_valid lie four registered
// stages: rotation multiply, rotation sum and clip, cross product multiply,
// final sum and clip. Throughput is one transaction per cycle while no result
// is held. A stall on dst while a result is waiting freezes all four stages
// together; src_stall is then raised so nothing is dropped or repeated.
// Bubbles move forward freely while no result is held.
// Reset empties the pipeline and loads the identity rotation and zero position.
module spatial_vector_transform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  svt_pkg::in_item_t             src_data,
  output logic                          dst_valid,
  input  logic                          dst_stall,
  output svt_pkg::out_item_t            dst_data,
  input  logic                          cfg_we,
  input  logic [svt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [svt_pkg::RotW-1:0]      cfg_data
);

  logic [2:0][47:0] rot;
  logic [2:0][31:0] pos;
  logic             en;
  logic             mid_valid;
  svt_pkg::mid_t    mid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= svt_pkg::ROT_ROW_0_RST;
      rot[1] <= svt_pkg::ROT_ROW_1_RST;
      rot[2] <= svt_pkg::ROT_ROW_2_RST;
      pos    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svt_pkg::CFG_ROT_ROW_0: rot[0] <= cfg_data;
        svt_pkg::CFG_ROT_ROW_1: rot[1] <= cfg_data;
        svt_pkg::CFG_ROT_ROW_2: rot[2] <= cfg_data;
        svt_pkg::CFG_POS_X:     pos[0] <= cfg_data[svt_pkg::PosW-1:0];
        svt_pkg::CFG_POS_Y:     pos[1] <= cfg_data[svt_pkg::PosW-1:0];
        svt_pkg::CFG_POS_Z:     pos[2] <= cfg_data[svt_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held by dst.
  assign en        = !dst_valid || !dst_stall;
  assign src_stall = !en;

  svt_rot_mul u_rot_mul (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (src_valid),
    .item       (src_data),
    .rot        (rot),
    .mid_valid  (mid_valid),
    .mid        (mid)
  );

  svt_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mid_valid (mid_valid),
    .mid       (mid),
    .pos       (pos),
    .res_valid (dst_valid),
    .res       (dst_data)
  );

endmodule

/* rtl/svt_checker.sv */
// Port-level checks for the spatial vector transform, bound to the top level.
module svt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 src_valid,
  input logic                 src_stall,
  input logic                 dst_valid,
  input logic                 dst_stall,
  input svt_pkg::out_item_t   dst_data
);

  // A held result stays put while dst stalls.
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid right after reset");

  // Input is stalled exactly when a result is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    src_stall == (dst_valid && dst_stall))
    else $error("src_stall does not follow the held result");

  // An accepted transaction reaches dst if dst does not stall while it moves through the stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) ##1 !dst_stall ##1 !dst_stall ##1 !dst_stall
      |=> dst_valid)
    else $error("transaction did not arrive after four cycles");

endmodule

bind spatial_vector_transform svt_checker u_svt_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for the spatial vector transform pipeline.
module testbench;
  import svt_pkg::*;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [79:0] wide_t;

  // Register indexes that map to no register.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_7 = 3'd7;
  localparam logic [15:0] ROT_ONE     = 16'h4000;
  localparam logic [15:0] ROT_NEG_ONE = 16'hC000;
  localparam int PIPE_DEPTH = 4;
  localparam int RUN_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  in_item_t src_data = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  out_item_t dst_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RotW-1:0] cfg_data = '0;

  // Local copy of the transform registers.
  logic [RotW-1:0] rot_model [3] = '{ROT_ROW_0_RST, ROT_ROW_1_RST, ROT_ROW_2_RST};
  q16_t pos_model [3] = '{32'sd0, 32'sd0, 32'sd0};

  out_item_t expected_q [$];
  out_item_t want_result;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_request = 0;
  int hold_off_left = 0;

  spatial_vector_transform u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact Q.30 product of one rotation row with a vector.
  function automatic wide_t row_dot(input int r, input q16_t x [3]);
    wide_t acc;
    wide_t ew;
    wide_t xw;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      ew = $signed(rot_model[r][16*c +: 16]);
      xw = x[c];
      acc = acc + ew * xw;
    end
    return acc;
  endfunction

  // Clip to the Q16.16 range and note any clip.
  function automatic q16_t clip_q16(input wide_t x, inout logic hit);
    if (x > SAT_MAX) begin
      hit = 1'b1;
      return SAT_MAX;
    end
    if (x < SAT_MIN) begin
      hit = 1'b1;
      return SAT_MIN;
    end
    return x[31:0];
  endfunction

  // Transformed vector: rotated part first, then rotated part plus p cross it.
  function automatic out_item_t transform_vector(input in_item_t v);
    q16_t lin [3];
    q16_t ang [3];
    q16_t rot_src [3];
    q16_t add_src [3];
    q16_t turned [3];
    q16_t moved [3];
    wide_t sum;
    wide_t pj;
    wide_t pk;
    wide_t tj;
    wide_t tk;
    logic hit;
    out_item_t r;
    int j;
    int k;
    lin = '{v.lin_x, v.lin_y, v.lin_z};
    ang = '{v.ang_x, v.ang_y, v.ang_z};
    hit = 1'b0;
    if (v.command == CMD_FORCE) begin
      rot_src = lin;
      add_src = ang;
    end else begin
      rot_src = ang;
      add_src = lin;
    end
    for (int i = 0; i < 3; i++) begin
      turned[i] = clip_q16(row_dot(i, rot_src) >>> 14, hit);
    end
    // The cross product takes the clipped rotated part.
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      pj = pos_model[j];
      pk = pos_model[k];
      tj = turned[j];
      tk = turned[k];
      sum = (row_dot(i, add_src) <<< 2) + pj * tk - pk * tj;
      moved[i] = clip_q16(sum >>> 16, hit);
    end
    if (v.command == CMD_FORCE) begin
      r.out_lin_x = turned[0];
      r.out_lin_y = turned[1];
      r.out_lin_z = turned[2];
      r.out_ang_x = moved[0];
      r.out_ang_y = moved[1];
      r.out_ang_z = moved[2];
    end else begin
      r.out_lin_x = moved[0];
      r.out_lin_y = moved[1];
      r.out_lin_z = moved[2];
      r.out_ang_x = turned[0];
      r.out_ang_y = turned[1];
      r.out_ang_z = turned[2];
    end
    r.saturated = hit;
    return r;
  endfunction

  function automatic in_item_t make_vector(input logic cmd, input q16_t lx, ly, lz,
                                           input q16_t ax, ay, az);
    in_item_t v;
    v.command = cmd;
    v.lin_x = lx;
    v.lin_y = ly;
    v.lin_z = lz;
    v.ang_x = ax;
    v.ang_y = ay;
    v.ang_z = az;
    return v;
  endfunction

  function automatic logic [RotW-1:0] rot_row(input logic [15:0] e0, e1, e2);
    return {e2, e1, e0};
  endfunction

  // Mix of small values, full-range values and the range limits.
  function automatic q16_t random_component();
    int unsigned pick;
    logic [31:0] r;
    pick = $urandom_range(99);
    r = $urandom;
    if (pick < 45) return $signed({{12{r[19]}}, r[19:0]});
    if (pick < 85) return r;
    case (r[2:0])
      3'd0: return SAT_MAX;
      3'd1: return SAT_MIN;
      3'd2: return 32'sd0;
      3'd3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Rotation entries: unit values, values within one, full range and limits.
  function automatic logic [15:0] random_rot_entry();
    int unsigned pick;
    logic [15:0] e;
    pick = $urandom_range(99);
    if (pick < 30) begin
      case ($urandom_range(2))
        0: e = 16'h0000;
        1: e = ROT_ONE;
        default: e = ROT_NEG_ONE;
      endcase
    end else if (pick < 75) begin
      e = 16'($urandom_range(16384));
      if ($urandom_range(1)) e = -e;
    end else if (pick < 90) begin
      e = 16'($urandom);
    end else begin
      e = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    end
    return e;
  endfunction

  function automatic logic [RotW-1:0] random_rot_row();
    return rot_row(random_rot_entry(), random_rot_entry(), random_rot_entry());
  endfunction

  function automatic void check_field(input string name, input q16_t want, input q16_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Register write; cfg_we stays high so writes can follow back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RotW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_ROT_ROW_0: rot_model[0] = data;
      CFG_ROT_ROW_1: rot_model[1] = data;
      CFG_ROT_ROW_2: rot_model[2] = data;
      CFG_POS_X: pos_model[0] = data[PosW-1:0];
      CFG_POS_Y: pos_model[1] = data[PosW-1:0];
      CFG_POS_Z: pos_model[2] = data[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_transform(input logic [RotW-1:0] r0, r1, r2,
                               input logic [RotW-1:0] px, py, pz);
    write_reg(CFG_ROT_ROW_0, r0);
    write_reg(CFG_ROT_ROW_1, r1);
    write_reg(CFG_ROT_ROW_2, r2);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_POS_Z, pz);
    cfg_we <= 1'b0;
  endtask

  // Position values carry random junk above bit 31.
  task automatic set_random_transform();
    set_transform(random_rot_row(), random_rot_row(), random_rot_row(),
                  {16'($urandom), random_component()},
                  {16'($urandom), random_component()},
                  {16'($urandom), random_component()});
  endtask

  // Offer one transaction, after random idle cycles, and hold it until accepted.
  task automatic send_vector(input in_item_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= v;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    expected_q.push_back(transform_vector(v));
  endtask

  task automatic send_random_vector();
    send_vector(make_vector(1'($urandom_range(1)), random_component(), random_component(),
                            random_component(), random_component(), random_component(),
                            random_component()));
  endtask

  task automatic wait_idle();
    src_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Reset values give the identity transform: vectors pass through unchanged.
  task automatic test_identity_after_reset();
    send_vector(make_vector(CMD_MOTION, 0, 0, 0, 0, 0, 0));
    send_vector(make_vector(CMD_MOTION, 32'sh0001_8000, -32'sh0000_4000, 7, -7,
                            32'sh0010_0000, -1));
    send_vector(make_vector(CMD_FORCE, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MAX));
    send_vector(make_vector(CMD_MOTION, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                            SAT_MIN));
    send_vector(make_vector(CMD_FORCE, SAT_MIN, SAT_MAX, 0, -1, 1, SAT_MAX));
    wait_idle();
  endtask

  // Saturation, saturated cross product operands, floor rounding, ignored writes.
  task automatic test_corner_cases();
    in_item_t neg_motion;
    in_item_t neg_force;
    neg_motion = make_vector(CMD_MOTION, -1, -3, 5, -1, -16383, 16385);
    neg_force = make_vector(CMD_FORCE, -5, 3, -16384, -1, -2, 7);

    // Most negative rotation entries and extreme positions.
    set_transform(rot_row(16'h8000, 16'h8000, 16'h8000),
                  rot_row(16'h8000, 16'h8000, 16'h8000),
                  rot_row(16'h8000, 16'h8000, 16'h8000),
                  48'(SAT_MAX), 48'(SAT_MIN), 48'(SAT_MAX));
    send_vector(make_vector(CMD_MOTION, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MAX));
    send_vector(make_vector(CMD_FORCE, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                            SAT_MIN));
    send_vector(make_vector(CMD_MOTION, 1, -1, 2, -2, 3, -3));
    wait_idle();

    // Most positive rotation entries with zero position.
    set_transform(rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                  rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                  rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF), '0, '0, '0);
    send_vector(make_vector(CMD_FORCE, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MAX));
    send_vector(make_vector(CMD_MOTION, SAT_MIN, SAT_MAX, 0, SAT_MAX, SAT_MIN, 0));
    wait_idle();

    // Tiny rotation so negative products floor rather than truncate.
    set_transform(rot_row(16'h0001, 16'h0000, 16'h0000),
                  rot_row(16'h0000, 16'h0001, 16'h0000),
                  rot_row(16'h0000, 16'h0000, 16'h0001),
                  {16'hA5A5, 32'sd1}, {16'h5A5A, -32'sd1}, {16'hFFFF, 32'sd3});
    send_vector(neg_motion);
    send_vector(neg_force);
    wait_idle();

    // Writes to indexes past the position registers change nothing.
    write_reg(CFG_UNUSED_6, '1);
    write_reg(CFG_UNUSED_7, 48'h5555_AAAA_5555);
    cfg_we <= 1'b0;
    send_vector(neg_motion);
    send_vector(neg_force);
    wait_idle();
  endtask

  // Random transactions under one idle pattern, with a new transform now and then.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        wait_idle();
        set_random_transform();
      end
      send_random_vector();
    end
    wait_idle();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_random_transform();
    hold_off_request = 150;
    for (int n = 0; n < 40; n++) begin
      send_random_vector();
    end
    wait_idle();
  endtask

  // Receiver stall: a requested long hold-off, else random stalls.
  always @(posedge clk) begin
    if (hold_off_request > 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left > 0) begin
      dst_stall <= 1'b1;
      hold_off_left--;
    end else begin
      dst_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no expected transaction");
        fail_count++;
      end else begin
        want_result = expected_q.pop_front();
        check_field("out_lin_x", want_result.out_lin_x, dst_data.out_lin_x);
        check_field("out_lin_y", want_result.out_lin_y, dst_data.out_lin_y);
        check_field("out_lin_z", want_result.out_lin_z, dst_data.out_lin_z);
        check_field("out_ang_x", want_result.out_ang_x, dst_data.out_ang_x);
        check_field("out_ang_y", want_result.out_ang_y, dst_data.out_ang_y);
        check_field("out_ang_z", want_result.out_ang_z, dst_data.out_ang_z);
        check_field("saturated", 32'(want_result.saturated), 32'(dst_data.saturated));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_identity_after_reset();
    test_corner_cases();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 81, 0);
    test_random_traffic(150, 0, 81);
    test_random_traffic(150, 8, 8);
    test_output_backpressure();
    wait_idle();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hung pipeline.
  initial begin
    #(RUN_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

/* spatial_vector_transform.f */
rtl/svt_pkg.sv
rtl/svt_rot_mul.sv
rtl/svt_cross.sv
rtl/spatial_vector_transform.sv
rtl/svt_checker.sv
tb/sv/testbench.sv
